/* rtl/jrp_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// Job request pacer package
// Widths, register indexes, event codes and reset values shared by the
// pacer design.
// ============================================================================
package jrp_pkg;

   // Field and datapath widths.
   localparam int NOW_W        = 48;
   localparam int COUNT_W      = 32;
   localparam int SUM_W        = COUNT_W + 1;
   localparam int MS_PER_SEC   = 1000;
   localparam int MS_PER_SEC_W = 10;
   localparam int NUM_W        = SUM_W + MS_PER_SEC_W;
   localparam int RATE_W       = 32;
   localparam int REQ_W        = 8;
   localparam int SRC_W        = 8;
   localparam int BASE_W       = 16;
   localparam int DELAY_W      = 20;
   localparam int ATT_W        = 4;
   localparam int BACKOFF_W    = BASE_W + (1 << ATT_W) - 1;
   localparam int DIV_CNT_W    = $clog2(NUM_W + 1);

   localparam logic [ATT_W-1:0]   ATT_MAX   = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [RATE_W-1:0]  RATE_MAX  = '1;

   // Stream words.
   localparam int REQ_TDATA_W = 56;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 2;

   // Configuration port.
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 20;

   localparam logic [CSR_INDEX_W-1:0] REG_MIN_REQUEST      = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_REQUEST      = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BCAST_BASE_DELAY = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BCAST_MAX_DELAY  = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ADHOC_BASE_DELAY = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_ADHOC_MAX_DELAY  = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_RATE_WINDOW      = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_ELAPSED      = 4'd7;

   // Register reset values.
   localparam logic [REQ_W-1:0]   RST_MIN_REQUEST      = 8'd5;
   localparam logic [REQ_W-1:0]   RST_MAX_REQUEST      = 8'd100;
   localparam logic [BASE_W-1:0]  RST_BCAST_BASE_DELAY = 16'd2000;
   localparam logic [DELAY_W-1:0] RST_BCAST_MAX_DELAY  = 20'd30000;
   localparam logic [BASE_W-1:0]  RST_ADHOC_BASE_DELAY = 16'd25;
   localparam logic [DELAY_W-1:0] RST_ADHOC_MAX_DELAY  = 20'd2000;
   localparam logic [DELAY_W-1:0] RST_RATE_WINDOW      = 20'd5000;
   localparam logic [BASE_W-1:0]  RST_MIN_ELAPSED      = 16'd50;

   // Event kinds.
   localparam logic OP_IMPORT = 1'b0;
   localparam logic OP_NEED   = 1'b1;

   // Parameter defaults.
   localparam int DEF_TIME_BITS = 48;
   localparam int DEF_BUCKET_MS = 1000;

endpackage

/* rtl/job_request_pacer.sv */
`timescale 1ns / 1ps
// ============================================================================
// Job request pacer
// Keeps a two-bucket import counter, estimates the import rate and decides
// broadcast and targeted requests for more work under exponential backoff.
// ============================================================================
// An import event passes through the import and hand-off states before the
// block is ready again. Most of a need event's time is spent in one
// bit-serial restoring divider that retires one quotient bit a cycle: a first
// pass over the 43-bit scaled count for the rate (count * 1000 / elapsed,
// rounded up) and a second pass over the 32-bit rate for the per-source share
// of that rate. The second pass is skipped when there are no sources, the first
// when the current bucket is older than the rate window. The result word sits
// in an output register, so the next event is taken while it waits to be read.
// Configuration words are taken at any time and must only be written while
// the block is idle.
module job_request_pacer
   import jrp_pkg::*;
#(
   parameter int TIME_BITS = DEF_TIME_BITS,
   parameter int BUCKET_MS = DEF_BUCKET_MS
) (
   input  logic                   clock,
   input  logic                   reset,
   // Event channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // now_ms[47:0], num_sources[55:48]
   input  logic [REQ_TUSER_W-1:0] req_tuser,   // op[0], reached_zero[1], new_source[2]
   // Result channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // request_count[7:0], import_rate[39:8]
   output logic [RSP_TUSER_W-1:0] rsp_tuser,   // send_broadcast[0], send_targeted[1]
   // Configuration write channel.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int REM_W = TIME_BITS + 1;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_WIN    = 9'b000000010,
      S_FLOOR  = 9'b000000100,
      S_DIV    = 9'b000001000,
      S_RATE   = 9'b000010000,
      S_FETCH  = 9'b000100000,
      S_DECIDE = 9'b001000000,
      S_IMPORT = 9'b010000000,
      S_OUT    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [REQ_W-1:0]   min_request_ff, max_request_ff;
   logic [BASE_W-1:0]  bcast_base_ff, adhoc_base_ff, min_elapsed_ff;
   logic [DELAY_W-1:0] bcast_max_ff, adhoc_max_ff, rate_window_ff;

   // Pacer state.
   logic [ATT_W-1:0]     bcast_att_ff, bcast_att_in;
   logic [ATT_W-1:0]     adhoc_att_ff, adhoc_att_in;
   logic [TIME_BITS-1:0] last_bcast_ff, last_bcast_in;
   logic [TIME_BITS-1:0] last_adhoc_ff, last_adhoc_in;
   logic [TIME_BITS-1:0] cur_time_ff, cur_time_in;
   logic [TIME_BITS-1:0] prev_time_ff, prev_time_in;
   logic [COUNT_W-1:0]   cur_count_ff, cur_count_in;
   logic [COUNT_W-1:0]   prev_count_ff, prev_count_in;

   // Captured event.
   logic                 op_ff, zero_ff, fresh_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [SRC_W-1:0]     src_ff;

   // Working registers.
   logic                 win_ok_ff, win_ok_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [NUM_W-1:0]     div_num_ff, div_num_in;
   logic [NUM_W-1:0]     div_quo_ff, div_quo_in;
   logic [REM_W-1:0]     div_rem_ff, div_rem_in;
   logic [TIME_BITS-1:0] div_den_ff, div_den_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 pass_ff, pass_in;
   logic [RATE_W-1:0]    rate_ff, rate_in;
   logic [DELAY_W-1:0]   bdelay_ff, bdelay_in;
   logic [DELAY_W-1:0]   adelay_ff, adelay_in;
   logic                 res_bc_ff, res_bc_in;
   logic                 res_tg_ff, res_tg_in;
   logic [REQ_W-1:0]     res_count_ff, res_count_in;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_TUSER_W-1:0] rsp_user_ff, rsp_user_in;

   // Elapsed times, saturating at zero when time runs backwards.
   logic [TIME_BITS:0]   d_cur, d_prev, d_bcast, d_adhoc;
   logic [TIME_BITS-1:0] since_cur, since_prev, since_bcast, since_adhoc;

   assign d_cur   = {1'b0, now_ff} - {1'b0, cur_time_ff};
   assign d_prev  = {1'b0, now_ff} - {1'b0, prev_time_ff};
   assign d_bcast = {1'b0, now_ff} - {1'b0, last_bcast_ff};
   assign d_adhoc = {1'b0, now_ff} - {1'b0, last_adhoc_ff};

   assign since_cur   = d_cur[TIME_BITS]   ? '0 : d_cur[TIME_BITS-1:0];
   assign since_prev  = d_prev[TIME_BITS]  ? '0 : d_prev[TIME_BITS-1:0];
   assign since_bcast = d_bcast[TIME_BITS] ? '0 : d_bcast[TIME_BITS-1:0];
   assign since_adhoc = d_adhoc[TIME_BITS] ? '0 : d_adhoc[TIME_BITS-1:0];

   // Handshakes.
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Datapath helpers.
   logic [REM_W-1:0]     rem_shift;
   logic                 rem_ge;
   logic [NUM_W:0]       rate_ceil;
   logic [RATE_W-1:0]    rate_sat;
   logic [TIME_BITS-1:0] elap_floor;
   logic [RATE_W-1:0]    fetch_raw;
   logic [REQ_W-1:0]     fetch_clamped;
   logic [BACKOFF_W-1:0] bshift, ashift;
   logic                 bc_fire, tg_fire;

   always_comb begin
      // One divider step: bring in the next numerator bit and try a subtract.
      rem_shift = {div_rem_ff[REM_W-2:0], div_num_ff[NUM_W-1]};
      rem_ge    = (rem_shift >= {1'b0, div_den_ff});

      // Round the rate up and saturate it to 32 bits.
      rate_ceil = {1'b0, div_quo_ff} + (NUM_W + 1)'(div_rem_ff != '0);
      rate_sat  = (rate_ceil[NUM_W:RATE_W] != '0) ? RATE_MAX : rate_ceil[RATE_W-1:0];

      // Floor the elapsed time, never below one millisecond.
      elap_floor = (div_den_ff < TIME_BITS'(min_elapsed_ff))
                   ? TIME_BITS'(min_elapsed_ff) : div_den_ff;
      if (elap_floor == '0) begin
         elap_floor = TIME_BITS'(1);
      end

      // Per-source count: the low clamp is tested before the high one.
      fetch_raw = (src_ff != '0) ? div_quo_ff[RATE_W-1:0] : RATE_W'(min_request_ff);
      if (fetch_raw < RATE_W'(min_request_ff)) begin
         fetch_clamped = min_request_ff;
      end else if (fetch_raw > RATE_W'(max_request_ff)) begin
         fetch_clamped = max_request_ff;
      end else begin
         fetch_clamped = fetch_raw[REQ_W-1:0];
      end

      // Backoff delays before the cap.
      bshift = BACKOFF_W'(bcast_base_ff) << bcast_att_ff;
      ashift = BACKOFF_W'(adhoc_base_ff) << adhoc_att_ff;

      // Send decisions.
      bc_fire = (since_bcast > TIME_BITS'(bdelay_ff));
      tg_fire = (zero_ff || (since_adhoc > TIME_BITS'(adelay_ff))) && (src_ff != '0);
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      bcast_att_in  = bcast_att_ff;
      adhoc_att_in  = adhoc_att_ff;
      last_bcast_in = last_bcast_ff;
      last_adhoc_in = last_adhoc_ff;
      cur_time_in   = cur_time_ff;
      prev_time_in  = prev_time_ff;
      cur_count_in  = cur_count_ff;
      prev_count_in = prev_count_ff;
      win_ok_in     = win_ok_ff;
      sum_in        = sum_ff;
      div_num_in    = div_num_ff;
      div_quo_in    = div_quo_ff;
      div_rem_in    = div_rem_ff;
      div_den_in    = div_den_ff;
      div_cnt_in    = div_cnt_ff;
      pass_in       = pass_ff;
      rate_in       = rate_ff;
      bdelay_in     = bdelay_ff;
      adelay_in     = adelay_ff;
      res_bc_in     = res_bc_ff;
      res_tg_in     = res_tg_ff;
      res_count_in  = res_count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;

      // The consumer takes the waiting word.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_tuser[0] == OP_NEED) ? S_WIN : S_IMPORT;
            end
         end

         // Rate window check, raw elapsed time and bucket sum.
         S_WIN: begin
            win_ok_in  = !(since_cur > TIME_BITS'(rate_window_ff));
            div_den_in = since_prev;
            sum_in     = SUM_W'(prev_count_ff) + SUM_W'(cur_count_ff);
            state_in   = S_FLOOR;
         end

         // Floor the divisor and scale the count to items per second.
         S_FLOOR: begin
            div_den_in = elap_floor;
            div_num_in = NUM_W'(sum_ff) * NUM_W'(MS_PER_SEC);
            div_quo_in = '0;
            div_rem_in = '0;
            div_cnt_in = DIV_CNT_W'(NUM_W);
            pass_in    = 1'b0;
            state_in   = win_ok_ff ? S_DIV : S_RATE;
         end

         // Bit-serial restoring division, one quotient bit a cycle.
         S_DIV: begin
            div_num_in = {div_num_ff[NUM_W-2:0], 1'b0};
            div_quo_in = {div_quo_ff[NUM_W-2:0], rem_ge};
            div_rem_in = rem_ge ? (rem_shift - {1'b0, div_den_ff}) : rem_shift;
            div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(1)) begin
               state_in = pass_ff ? S_FETCH : S_RATE;
            end
         end

         // Rate result; start the per-source share if there are sources and work is due.
         S_RATE: begin
            rate_in = rate_sat;
            if (zero_ff && (rate_sat == '0)) begin
               res_bc_in    = 1'b0;
               res_tg_in    = 1'b0;
               res_count_in = '0;
               state_in     = S_OUT;
            end else if (src_ff != '0) begin
               div_num_in = {rate_sat, (NUM_W - RATE_W)'(0)};
               div_den_in = TIME_BITS'(src_ff);
               div_quo_in = '0;
               div_rem_in = '0;
               div_cnt_in = DIV_CNT_W'(RATE_W);
               pass_in    = 1'b1;
               state_in   = S_DIV;
            end else begin
               state_in = S_FETCH;
            end
         end

         // Clamp the count and cap both backoff delays.
         S_FETCH: begin
            res_count_in = fetch_clamped;
            bdelay_in    = (bshift > BACKOFF_W'(bcast_max_ff)) ? bcast_max_ff
                                                               : bshift[DELAY_W-1:0];
            adelay_in    = (ashift > BACKOFF_W'(adhoc_max_ff)) ? adhoc_max_ff
                                                               : ashift[DELAY_W-1:0];
            state_in     = S_DECIDE;
         end

         // Send decisions and backoff bookkeeping.
         S_DECIDE: begin
            res_bc_in = bc_fire;
            res_tg_in = tg_fire;
            if (bc_fire) begin
               last_bcast_in = now_ff;
               bcast_att_in  = (bcast_att_ff == ATT_MAX) ? ATT_MAX
                                                         : bcast_att_ff + ATT_W'(1);
            end
            if (tg_fire) begin
               last_adhoc_in = now_ff;
               adhoc_att_in  = (adhoc_att_ff == ATT_MAX) ? ATT_MAX
                                                         : adhoc_att_ff + ATT_W'(1);
            end
            state_in = S_OUT;
         end

         // Count one import, rolling the buckets when the current one is old.
         S_IMPORT: begin
            if (since_cur > TIME_BITS'(BUCKET_MS)) begin
               prev_time_in  = cur_time_ff;
               prev_count_in = cur_count_ff;
               cur_time_in   = now_ff;
               cur_count_in  = COUNT_W'(1);
            end else if (cur_count_ff != COUNT_MAX) begin
               cur_count_in = cur_count_ff + COUNT_W'(1);
            end
            adhoc_att_in = '0;
            if (fresh_ff) begin
               bcast_att_in = '0;
            end
            rate_in      = '0;
            res_bc_in    = 1'b0;
            res_tg_in    = 1'b0;
            res_count_in = '0;
            state_in     = S_OUT;
         end

         // Hand the result to the output register once it is free.
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {rate_ff, res_count_ff};
               rsp_user_in  = {res_tg_ff, res_bc_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state and pacer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         bcast_att_ff   <= '0;
         adhoc_att_ff   <= '0;
         last_bcast_ff  <= '0;
         last_adhoc_ff  <= '0;
         cur_time_ff    <= '0;
         prev_time_ff   <= '0;
         cur_count_ff   <= '0;
         prev_count_ff  <= '0;
         min_request_ff <= RST_MIN_REQUEST;
         max_request_ff <= RST_MAX_REQUEST;
         bcast_base_ff  <= RST_BCAST_BASE_DELAY;
         bcast_max_ff   <= RST_BCAST_MAX_DELAY;
         adhoc_base_ff  <= RST_ADHOC_BASE_DELAY;
         adhoc_max_ff   <= RST_ADHOC_MAX_DELAY;
         rate_window_ff <= RST_RATE_WINDOW;
         min_elapsed_ff <= RST_MIN_ELAPSED;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         bcast_att_ff  <= bcast_att_in;
         adhoc_att_ff  <= adhoc_att_in;
         last_bcast_ff <= last_bcast_in;
         last_adhoc_ff <= last_adhoc_in;
         cur_time_ff   <= cur_time_in;
         prev_time_ff  <= prev_time_in;
         cur_count_ff  <= cur_count_in;
         prev_count_ff <= prev_count_in;
         // Configuration word.
         if (csr_valid) begin
            case (csr_index)
               REG_MIN_REQUEST:      min_request_ff <= csr_data[REQ_W-1:0];
               REG_MAX_REQUEST:      max_request_ff <= csr_data[REQ_W-1:0];
               REG_BCAST_BASE_DELAY: bcast_base_ff  <= csr_data[BASE_W-1:0];
               REG_BCAST_MAX_DELAY:  bcast_max_ff   <= csr_data[DELAY_W-1:0];
               REG_ADHOC_BASE_DELAY: adhoc_base_ff  <= csr_data[BASE_W-1:0];
               REG_ADHOC_MAX_DELAY:  adhoc_max_ff   <= csr_data[DELAY_W-1:0];
               REG_RATE_WINDOW:      rate_window_ff <= csr_data[DELAY_W-1:0];
               REG_MIN_ELAPSED:      min_elapsed_ff <= csr_data[BASE_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff    <= req_tuser[0];
         zero_ff  <= req_tuser[1];
         fresh_ff <= req_tuser[2];
         now_ff   <= TIME_BITS'(req_tdata[NOW_W-1:0]);
         src_ff   <= req_tdata[NOW_W+SRC_W-1:NOW_W];
      end
      win_ok_ff    <= win_ok_in;
      sum_ff       <= sum_in;
      div_num_ff   <= div_num_in;
      div_quo_ff   <= div_quo_in;
      div_rem_ff   <= div_rem_in;
      div_den_ff   <= div_den_in;
      div_cnt_ff   <= div_cnt_in;
      pass_ff      <= pass_in;
      rate_ff      <= rate_in;
      bdelay_ff    <= bdelay_in;
      adelay_ff    <= adelay_in;
      res_bc_ff    <= res_bc_in;
      res_tg_ff    <= res_tg_in;
      res_count_ff <= res_count_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

`ifndef ASSERT_OFF
   // The divider never runs with an exhausted step count.
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_cnt_ff != '0))
      else $error("divider running with zero steps left");

   // An import goes straight to the result hand-off and clears targeted backoff.
   a_import_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IMPORT) |=> (adhoc_att_ff == '0) && (state_ff == S_OUT)
                                  && (op_ff == OP_IMPORT))
      else $error("import event did not clear targeted attempts");

   // A broadcast stamps its own time.
   a_bcast_stamp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE) && bc_fire |=> (last_bcast_ff == $past(now_ff)))
      else $error("broadcast time not recorded");
`endif

endmodule

/* dv/tb_job_request_pacer.sv */
`timescale 1ns / 1ps
// ============================================================================
// Job request pacer testbench
// Streams import and need events into the pacer and predicts every result
// word from a behavioural model of the bucket counter, the rate estimate and
// the two backoff timers. The run covers several register settings, among
// them the extremes, random idling on both streams and deliberate stalls.
// ============================================================================
module tb_job_request_pacer;
   import jrp_pkg::*;

   localparam int          CYCLE_LIMIT = 1000000;
   localparam int          BUCKET_LEN  = DEF_BUCKET_MS;
   localparam logic [47:0] MS_TOP      = '1;

   typedef struct packed {
      logic        op;
      logic [47:0] now_ms;
      logic        reached_zero;
      logic [7:0]  num_sources;
      logic        new_source;
   } pacer_event_type;

   typedef struct packed {
      logic        send_broadcast;
      logic        send_targeted;
      logic [7:0]  request_count;
      logic [31:0] import_rate;
   } pacer_decision_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // now_ms[47:0], num_sources[55:48]
   logic [REQ_TUSER_W-1:0] req_tuser = '0;   // op[0], reached_zero[1], new_source[2]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // request_count[7:0], import_rate[39:8]
   logic [RSP_TUSER_W-1:0] rsp_tuser;        // send_broadcast[0], send_targeted[1]
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   job_request_pacer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Event words waiting to be sent and decisions waiting to be returned.
   pacer_event_type    event_backlog[$];
   pacer_decision_type due_decisions[$];
   pacer_event_type    held_event;

   // Predicted register settings.
   logic [7:0]  min_fetch  = RST_MIN_REQUEST;
   logic [7:0]  max_fetch  = RST_MAX_REQUEST;
   logic [15:0] bcast_base = RST_BCAST_BASE_DELAY;
   logic [19:0] bcast_cap  = RST_BCAST_MAX_DELAY;
   logic [15:0] adhoc_base = RST_ADHOC_BASE_DELAY;
   logic [19:0] adhoc_cap  = RST_ADHOC_MAX_DELAY;
   logic [19:0] window_ms  = RST_RATE_WINDOW;
   logic [15:0] floor_ms   = RST_MIN_ELAPSED;

   // Predicted pacer state.
   logic [3:0]  bcast_tries   = '0;
   logic [3:0]  adhoc_tries   = '0;
   logic [47:0] bcast_last_ms = '0;
   logic [47:0] adhoc_last_ms = '0;
   logic [47:0] bucket_now_ms = '0;
   logic [31:0] bucket_now_n  = '0;
   logic [47:0] bucket_old_ms = '0;
   logic [31:0] bucket_old_n  = '0;

   logic [47:0] clock_ms = '0;
   int          snd_idle_pct = 0;
   int          rcv_idle_pct = 0;
   int          hold_left = 0;
   int unsigned cycle_count = 0;
   int unsigned mismatches = 0;
   int unsigned results_seen = 0;
   int unsigned imports_taken = 0;
   int unsigned needs_taken = 0;
   int unsigned idle_needs = 0;
   int unsigned broadcasts = 0;
   int unsigned targeted = 0;
   int unsigned settings_loaded = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Elapsed milliseconds, held at zero when time has gone backwards.
   function automatic longint unsigned ms_since(input logic [47:0] now_t,
                                                input logic [47:0] then_t);
      if (now_t >= then_t) return now_t - then_t;
      return 0;
   endfunction

   function automatic longint unsigned backoff_ms(input logic [15:0] base,
                                                  input logic [3:0] tries,
                                                  input logic [19:0] cap);
      longint unsigned span;
      span = base;
      span = span << tries;
      if (span > cap) span = cap;
      return span;
   endfunction

   // Works out the decision for one event and advances the predicted state.
   function automatic pacer_decision_type pace_event(input pacer_event_type ev);
      pacer_decision_type dec;
      longint unsigned elapsed;
      longint unsigned scaled;
      longint unsigned rate;
      longint unsigned share;
      dec = '0;
      if (ev.op == OP_IMPORT) begin
         imports_taken++;
         if (ms_since(ev.now_ms, bucket_now_ms) > BUCKET_LEN) begin
            bucket_old_ms = bucket_now_ms;
            bucket_old_n  = bucket_now_n;
            bucket_now_ms = ev.now_ms;
            bucket_now_n  = '0;
         end
         if (bucket_now_n != COUNT_MAX) bucket_now_n = bucket_now_n + 1'b1;
         adhoc_tries = '0;
         if (ev.new_source) bcast_tries = '0;
         return dec;
      end
      needs_taken++;

      // Rate as a rounded-up quotient, zero once the current bucket is stale.
      rate = 0;
      if (ms_since(ev.now_ms, bucket_now_ms) <= window_ms) begin
         elapsed = ms_since(ev.now_ms, bucket_old_ms);
         if (elapsed < floor_ms) elapsed = floor_ms;
         if (elapsed == 0) elapsed = 1;
         scaled = bucket_old_n;
         scaled = (scaled + bucket_now_n) * MS_PER_SEC;
         rate = scaled / elapsed;
         if (scaled % elapsed != 0) rate++;
         if (rate > RATE_MAX) rate = RATE_MAX;
      end
      dec.import_rate = rate[31:0];

      // An emptied queue with no imports coming in asks for nothing.
      if (ev.reached_zero && rate == 0) begin
         idle_needs++;
         return dec;
      end

      share = min_fetch;
      if (ev.num_sources != 0) share = rate / ev.num_sources;
      if (share < min_fetch) share = min_fetch;
      else if (share > max_fetch) share = max_fetch;
      dec.request_count = share[7:0];

      if (ms_since(ev.now_ms, bcast_last_ms) >
          backoff_ms(bcast_base, bcast_tries, bcast_cap)) begin
         bcast_last_ms = ev.now_ms;
         if (bcast_tries != ATT_MAX) bcast_tries = bcast_tries + 1'b1;
         dec.send_broadcast = 1'b1;
      end

      if ((ev.reached_zero || ms_since(ev.now_ms, adhoc_last_ms) >
           backoff_ms(adhoc_base, adhoc_tries, adhoc_cap)) && ev.num_sources != 0) begin
         adhoc_last_ms = ev.now_ms;
         if (adhoc_tries != ATT_MAX) adhoc_tries = adhoc_tries + 1'b1;
         dec.send_targeted = 1'b1;
      end
      return dec;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] MISMATCH: %s", $time, msg);
   endtask

   // Event driver: offers the backlog one word at a time, with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) due_decisions.push_back(pace_event(held_event));
         if (!req_tvalid || req_tready) begin
            if (event_backlog.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
               held_event = event_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {held_event.num_sources, held_event.now_ms};
               req_tuser  <= {held_event.new_source, held_event.reached_zero,
                              held_event.op};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each word and paces rsp_tready, with a long
   // hold-off now and then so that the pacer backs up onto its input.
   always @(posedge clock) begin
      pacer_decision_type got;
      pacer_decision_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got.send_broadcast = rsp_tuser[0];
            got.send_targeted  = rsp_tuser[1];
            got.request_count  = rsp_tdata[7:0];
            got.import_rate    = rsp_tdata[39:8];
            broadcasts += got.send_broadcast;
            targeted   += got.send_targeted;
            if (due_decisions.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with none expected",
                                         results_seen));
            end else begin
               want = due_decisions.pop_front();
               if (got.send_broadcast !== want.send_broadcast)
                  report_mismatch($sformatf("result %0d send_broadcast %b, expected %b",
                                            results_seen, got.send_broadcast,
                                            want.send_broadcast));
               if (got.send_targeted !== want.send_targeted)
                  report_mismatch($sformatf("result %0d send_targeted %b, expected %b",
                                            results_seen, got.send_targeted,
                                            want.send_targeted));
               if (got.request_count !== want.request_count)
                  report_mismatch($sformatf("result %0d request_count %0d, expected %0d",
                                            results_seen, got.request_count,
                                            want.request_count));
               if (got.import_rate !== want.import_rate)
                  report_mismatch($sformatf("result %0d import_rate %0d, expected %0d",
                                            results_seen, got.import_rate,
                                            want.import_rate));
            end
            if (results_seen % 250 == 120) hold_left = 400;
         end else if (hold_left > 0) begin
            hold_left--;
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding",
                  cycle_count, due_decisions.size());
         $display("job_request_pacer verification failed");
         $finish;
      end
   end

   // Sender pause: nothing more is offered until every decision is back.
   // Sampled on the falling edge so that the driver's updates have settled.
   task automatic wait_drained();
      do @(negedge clock);
      while (event_backlog.size() != 0 || req_tvalid || due_decisions.size() != 0);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         REG_MIN_REQUEST:      min_fetch  = value[7:0];
         REG_MAX_REQUEST:      max_fetch  = value[7:0];
         REG_BCAST_BASE_DELAY: bcast_base = value[15:0];
         REG_BCAST_MAX_DELAY:  bcast_cap  = value;
         REG_ADHOC_BASE_DELAY: adhoc_base = value[15:0];
         REG_ADHOC_MAX_DELAY:  adhoc_cap  = value;
         REG_RATE_WINDOW:      window_ms  = value;
         REG_MIN_ELAPSED:      floor_ms   = value[15:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(input logic [19:0] lo_req, input logic [19:0] hi_req,
                                input logic [19:0] bc_base, input logic [19:0] bc_cap,
                                input logic [19:0] ah_base, input logic [19:0] ah_cap,
                                input logic [19:0] win, input logic [19:0] flr);
      write_reg(REG_MIN_REQUEST, lo_req);
      write_reg(REG_MAX_REQUEST, hi_req);
      write_reg(REG_BCAST_BASE_DELAY, bc_base);
      write_reg(REG_BCAST_MAX_DELAY, bc_cap);
      write_reg(REG_ADHOC_BASE_DELAY, ah_base);
      write_reg(REG_ADHOC_MAX_DELAY, ah_cap);
      write_reg(REG_RATE_WINDOW, win);
      write_reg(REG_MIN_ELAPSED, flr);
      settings_loaded++;
   endtask

   task automatic load_random_settings(input bit zero_floor);
      logic [19:0] flr;
      flr = zero_floor ? 20'd0 : 20'($urandom_range(1, 2000));
      load_settings(20'($urandom_range(1, 16)), 20'($urandom_range(1, 255)),
                    20'($urandom_range(1, 4000)), 20'($urandom_range(1, 100000)),
                    20'($urandom_range(1, 200)), 20'($urandom_range(1, 5000)),
                    20'($urandom_range(200, 20000)), flr);
   endtask

   task automatic add_event(input logic op, input logic [47:0] now_ms,
                            input logic reached_zero, input logic [7:0] num_sources,
                            input logic new_source);
      pacer_event_type ev;
      ev.op           = op;
      ev.now_ms       = now_ms;
      ev.reached_zero = reached_zero;
      ev.num_sources  = num_sources;
      ev.new_source   = new_source;
      event_backlog.push_back(ev);
   endtask

   // Moves the event clock on: mostly small steps, sometimes across buckets
   // or windows, sometimes backwards, and now and then to a random point.
   task automatic advance_clock();
      int          pick;
      logic [47:0] step;
      logic [63:0] wide;
      pick = $urandom_range(99);
      wide = {$urandom(), $urandom()};
      if (pick < 50) begin
         clock_ms = clock_ms + 48'($urandom_range(0, 60));
      end else if (pick < 75) begin
         clock_ms = clock_ms + 48'($urandom_range(60, 1500));
      end else if (pick < 87) begin
         clock_ms = clock_ms + 48'($urandom_range(1500, 40000));
      end else if (pick < 96) begin
         step = 48'($urandom_range(0, 2000));
         clock_ms = (clock_ms > step) ? clock_ms - step : '0;
      end else if (pick < 98) begin
         clock_ms = wide[47:0];
      end else begin
         clock_ms = wide[0] ? MS_TOP : '0;
      end
   endtask

   // Runs of imports and runs of need events with random content, plus a
   // share of words with every field random.
   task automatic queue_random_events(input int count);
      int              run_left;
      int              pick;
      logic            run_op;
      logic [63:0]     wide;
      pacer_event_type ev;
      run_left = 0;
      run_op   = OP_IMPORT;
      for (int n = 0; n < count; n++) begin
         if (run_left == 0) begin
            run_op   = ($urandom_range(99) < 45) ? OP_IMPORT : OP_NEED;
            run_left = $urandom_range(1, 12);
         end
         run_left--;
         advance_clock();
         ev.op           = run_op;
         ev.now_ms       = clock_ms;
         ev.reached_zero = ($urandom_range(3) == 0);
         pick = $urandom_range(99);
         if (pick < 20) ev.num_sources = '0;
         else if (pick < 70) ev.num_sources = 8'($urandom_range(1, 8));
         else ev.num_sources = 8'($urandom_range(0, 255));
         ev.new_source = ($urandom_range(4) == 0);
         if ($urandom_range(99) < 8) begin
            wide = {$urandom(), $urandom()};
            ev = wide[58:0];
         end
         event_backlog.push_back(ev);
      end
   endtask

   task automatic set_idling(input int snd, input int rcv);
      snd_idle_pct = snd;
      rcv_idle_pct = rcv;
   endtask

   // Test sequence.
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      set_idling(31, 58);

      // Directed events under the reset settings.
      add_event(OP_NEED, 48'd0, 1'b1, 8'd0, 1'b0);      // emptied, no rate: idle
      add_event(OP_NEED, 48'd0, 1'b0, 8'd0, 1'b0);      // no sources: low clamp
      add_event(OP_IMPORT, 48'd10, 1'b0, 8'd0, 1'b1);   // new source
      add_event(OP_IMPORT, 48'd20, 1'b1, 8'd255, 1'b0); // need fields ignored
      add_event(OP_NEED, 48'd3000, 1'b0, 8'd255, 1'b1); // broadcast due
      add_event(OP_NEED, 48'd3001, 1'b1, 8'd1, 1'b0);   // emptied forces targeted
      for (int i = 0; i < 8; i++)
         add_event(OP_IMPORT, 48'd3500 + 48'(i), 1'b0, 8'd0, 1'b0);
      add_event(OP_NEED, 48'd3520, 1'b0, 8'd1, 1'b0);
      add_event(OP_NEED, 48'd100, 1'b0, 8'd2, 1'b0);    // time gone backwards
      add_event(OP_NEED, MS_TOP, 1'b0, 8'd3, 1'b0);     // window expired
      add_event(OP_NEED, MS_TOP, 1'b1, 8'd3, 1'b0);
      add_event(OP_IMPORT, MS_TOP, 1'b0, 8'd0, 1'b1);
      add_event(OP_NEED, MS_TOP, 1'b0, 8'd200, 1'b1);
      add_event(OP_IMPORT, 48'd0, 1'b1, 8'd128, 1'b0);
      add_event(OP_NEED, 48'd0, 1'b0, 8'd1, 1'b1);      // elapsed below the floor
      add_event(OP_NEED, 48'd0, 1'b1, 8'd0, 1'b0);
      wait_drained();

      queue_random_events(190);
      wait_drained();

      // Smallest delays and floor, widest clamp and window.
      load_settings(20'd1, 20'd255, 20'd1, 20'd1, 20'd1, 20'd1, 20'hFFFFF, 20'd1);
      queue_random_events(190);
      wait_drained();

      // Largest delays, inverted clamp, narrowest window.
      set_idling(58, 31);
      load_settings(20'd255, 20'd1, 20'hFFFF, 20'hFFFFF, 20'hFFFF, 20'hFFFFF, 20'd1,
                    20'hFFFF);
      queue_random_events(190);
      wait_drained();

      // No floor on the elapsed time.
      load_random_settings(1'b1);
      queue_random_events(190);
      wait_drained();

      set_idling(0, 0);
      load_random_settings(1'b0);
      queue_random_events(190);
      wait_drained();
      load_random_settings(1'b0);
      queue_random_events(190);
      wait_drained();

      repeat (100) @(posedge clock);
      if (due_decisions.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", due_decisions.size()));

      $display("Covered %0d import and %0d need events (%0d idle after emptying) under %0d",
               imports_taken, needs_taken, idle_needs, settings_loaded + 1);
      $display("register settings; %0d broadcasts and %0d targeted requests, %0d mismatches",
               broadcasts, targeted, mismatches);
      if (mismatches == 0) begin
         $display("job_request_pacer verification clean");
      end else begin
         $display("job_request_pacer verification failed");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/jrp_pkg.sv
rtl/job_request_pacer.sv
dv/tb_job_request_pacer.sv
